@@ rtl/core/hcbp_pkg.sv @@
// Shared constants, codes and payload types of the Huffman code bit packer.
package hcbp_pkg;

  localparam int TABLE_DEPTH  = 1024;
  localparam int MAX_CODE_LEN = 32;

  localparam int OP_W    = 2;
  localparam int SYM_W   = 10;
  localparam int CODE_W  = 32;
  localparam int LEN_W   = 6;
  localparam int BYTE_W  = 8;
  localparam int PEND_W  = 7;
  localparam int CNT_W   = 3;

  localparam int TAB_AW  = $clog2(TABLE_DEPTH);
  localparam int ENTRY_W = LEN_W + CODE_W;
  localparam int AL_W    = MAX_CODE_LEN;
  localparam int ACC_W   = AL_W + PEND_W;
  localparam int REM_W   = $clog2(ACC_W + 1);

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    CMD_ENCODE,
    CMD_MISS,
    CMD_FLUSH
  } cmd_kind_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] code_word;
    logic [LEN_W-1:0]  code_length;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              is_miss;
    logic              last;
  } out_item_t;

  // Code is left aligned: first bit in the top position.
  typedef struct packed {
    cmd_kind_t         kind;
    logic [AL_W-1:0]   code;
    logic [LEN_W-1:0]  len;
  } cmd_t;

  typedef struct packed {
    logic            valid;
    logic [Q_CW-1:0] level;
  } q_status_t;

endpackage

@@ rtl/core/huffman_code_bit_packer_unit.sv @@
// Top level of the Huffman code bit packer: front end, command queue, packer.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+--------------------------------
//   in_     | request   | in_push / in_full      | op, symbol, code_word, code_length
//   out_    | result    | out_empty / out_pop    | out_byte, is_miss, last
//
// Flow: the front end takes one request per cycle while in_full is low; load
// requests write the code table at once, encode and flush requests read it
// and enter the command queue in the cycle after they are taken; a request
// that finds the packer idle passes the table read register, the command
// queue and the output register before its first byte shows. The packer
// sends one byte per cycle while the output register has room, out of a 39
// bit shift register.
// Reset: rst_n is synchronous; afterwards the front end zeroes all 1024 table
// entries, one per cycle, and holds in_full high until the last is written.
// Stalls: in_full rises when the four entry command queue has no room for the
// request in flight; a result waiting in the output register does not block
// new requests until the queue fills.
module huffman_code_bit_packer_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  hcbp_pkg::in_item_t  in_item,
  output logic                in_full,
  output logic                out_empty,
  input  logic                out_pop,
  output hcbp_pkg::out_item_t out_item
);

  hcbp_pkg::q_status_t q_stat;
  hcbp_pkg::cmd_t      front_cmd;
  hcbp_pkg::cmd_t      head_cmd;
  logic                cmd_push;
  logic                cmd_pop;
  logic                pop_ok;

  // Front end: classify requests, own the code table.
  hcbp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_item  (in_item),
    .in_full  (in_full),
    .q_stat   (q_stat),
    .cmd_push (cmd_push),
    .cmd      (front_cmd)
  );

  // Decouple classification from byte emission.
  hcbp_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .push_cmd (front_cmd),
    .pop      (cmd_pop),
    .head     (head_cmd),
    .q_stat   (q_stat)
  );

  // Only a pop against a waiting result advances the output register.
  assign pop_ok = out_pop && !out_empty;

  // Packer: drain commands, emit bytes.
  hcbp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .head      (head_cmd),
    .q_pop     (cmd_pop),
    .out_empty (out_empty),
    .out_pop   (pop_ok),
    .out_item  (out_item)
  );

endmodule

@@ rtl/core/hcbp_ram.sv @@
// Generic single write port, single read port RAM with registered read.
module hcbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/hcbp_front.sv @@
// Front end: accepts requests, owns the code table, classifies into commands.
module hcbp_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  hcbp_pkg::in_item_t  in_item,
  output logic                in_full,
  input  hcbp_pkg::q_status_t q_stat,
  output logic                cmd_push,
  output hcbp_pkg::cmd_t      cmd
);

  localparam int WIDE_W = hcbp_pkg::AL_W + hcbp_pkg::CODE_W;

  logic                                        clr_r, clr_nxt;
  logic [hcbp_pkg::TAB_AW-1:0]                 clr_addr_r, clr_addr_nxt;
  logic                                        s1_valid_r, s1_valid_nxt;
  logic                                        s1_flush_r, s1_range_r;
  logic                                        accept;
  logic                                        in_range;
  logic [31:0]                                 sym_ext;
  logic [hcbp_pkg::Q_CW:0]                     occupancy;
  logic [hcbp_pkg::LEN_W-1:0]                  len_sat;
  logic [hcbp_pkg::CODE_W-1:0]                 code_masked;
  logic                                        ram_we;
  logic [hcbp_pkg::TAB_AW-1:0]                 ram_waddr;
  logic [hcbp_pkg::ENTRY_W-1:0]                ram_wdata;
  logic [hcbp_pkg::ENTRY_W-1:0]                ram_rdata;
  logic [hcbp_pkg::LEN_W-1:0]                  rd_len;
  logic [hcbp_pkg::CODE_W-1:0]                 rd_code;
  logic [hcbp_pkg::LEN_W-1:0]                  align_sh;
  logic [WIDE_W-1:0]                           code_wide;

  // Hold off requests while the table is cleared and while the queue could overflow.
  assign occupancy = (hcbp_pkg::Q_CW + 1)'(q_stat.level) + (hcbp_pkg::Q_CW + 1)'(s1_valid_r);
  assign in_full   = clr_r || (occupancy >= (hcbp_pkg::Q_CW + 1)'(hcbp_pkg::Q_DEPTH));
  assign accept    = in_push && !in_full;

  assign sym_ext  = 32'(in_item.symbol);
  assign in_range = sym_ext < 32'(hcbp_pkg::TABLE_DEPTH);

  always_comb begin
    if (in_item.code_length > hcbp_pkg::LEN_W'(hcbp_pkg::MAX_CODE_LEN)) begin
      len_sat = hcbp_pkg::LEN_W'(hcbp_pkg::MAX_CODE_LEN);
    end else begin
      len_sat = in_item.code_length;
    end
    // Drop code bits above the length; a shift by the full width leaves the mask all ones.
    code_masked = in_item.code_word & ~({hcbp_pkg::CODE_W{1'b1}} << len_sat);
  end

  assign ram_we    = clr_r || (accept && (in_item.op == hcbp_pkg::OP_LOAD) && in_range);
  assign ram_waddr = clr_r ? clr_addr_r : hcbp_pkg::TAB_AW'(in_item.symbol);
  assign ram_wdata = clr_r ? '0 : {len_sat, code_masked};

  hcbp_ram #(
    .WIDTH (hcbp_pkg::ENTRY_W),
    .DEPTH (hcbp_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (hcbp_pkg::TAB_AW'(in_item.symbol)),
    .rdata (ram_rdata)
  );

  always_comb begin
    clr_nxt      = clr_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_r) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (clr_addr_r == hcbp_pkg::TAB_AW'(hcbp_pkg::TABLE_DEPTH - 1)) begin
        clr_nxt = 1'b0;
      end
    end
    s1_valid_nxt = accept && ((in_item.op == hcbp_pkg::OP_ENCODE) ||
                              (in_item.op == hcbp_pkg::OP_FLUSH));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      clr_r      <= clr_nxt;
      clr_addr_r <= clr_addr_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_flush_r <= (in_item.op == hcbp_pkg::OP_FLUSH);
    s1_range_r <= in_range;
  end

  // Table entry arrives now; classify and left align the code.
  assign rd_len    = ram_rdata[hcbp_pkg::ENTRY_W-1 -: hcbp_pkg::LEN_W];
  assign rd_code   = ram_rdata[hcbp_pkg::CODE_W-1:0];
  assign align_sh  = hcbp_pkg::LEN_W'(hcbp_pkg::MAX_CODE_LEN) - rd_len;
  assign code_wide = WIDE_W'(rd_code) << align_sh;

  always_comb begin
    cmd.code = code_wide[hcbp_pkg::AL_W-1:0];
    cmd.len  = rd_len;
    if (s1_flush_r) begin
      cmd.kind = hcbp_pkg::CMD_FLUSH;
    end else if (!s1_range_r || (rd_len == '0)) begin
      cmd.kind = hcbp_pkg::CMD_MISS;
    end else begin
      cmd.kind = hcbp_pkg::CMD_ENCODE;
    end
  end

  assign cmd_push = s1_valid_r;

endmodule

@@ rtl/core/hcbp_cmdq.sv @@
// Short command queue between the front end and the packer.
module hcbp_cmdq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  hcbp_pkg::cmd_t      push_cmd,
  input  logic                pop,
  output hcbp_pkg::cmd_t      head,
  output hcbp_pkg::q_status_t q_stat
);

  hcbp_pkg::cmd_t              mem_r [hcbp_pkg::Q_DEPTH];
  logic [hcbp_pkg::Q_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [hcbp_pkg::Q_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [hcbp_pkg::Q_CW-1:0]   level_r, level_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    level_nxt  = level_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == hcbp_pkg::Q_AW'(hcbp_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == hcbp_pkg::Q_AW'(hcbp_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      level_nxt = level_r + 1'b1;
    end else if (pop && !push) begin
      level_nxt = level_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign head         = mem_r[rd_ptr_r];
  assign q_stat.valid = (level_r != '0);
  assign q_stat.level = level_r;

endmodule

@@ rtl/core/hcbp_back.sv @@
// Back end: packs code bits into bytes, one per cycle while the output has room.
module hcbp_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  hcbp_pkg::q_status_t  q_stat,
  input  hcbp_pkg::cmd_t       head,
  output logic                 q_pop,
  output logic                 out_empty,
  input  logic                 out_pop,
  output hcbp_pkg::out_item_t  out_item
);

  logic                         busy_r, busy_nxt;
  logic [hcbp_pkg::ACC_W-1:0]   work_r, work_nxt;
  logic [hcbp_pkg::REM_W-1:0]   rem_r, rem_nxt;
  logic [hcbp_pkg::PEND_W-1:0]  pend_r, pend_nxt;
  logic [hcbp_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                         out_valid_r, out_valid_nxt;
  hcbp_pkg::out_item_t          out_data_r, out_data_nxt;

  logic                         out_space;
  logic                         q_take;
  logic [hcbp_pkg::ACC_W-1:0]   fresh_work;
  logic [hcbp_pkg::REM_W-1:0]   fresh_total;
  logic [hcbp_pkg::ACC_W-1:0]   src_work, shift_work;
  logic [hcbp_pkg::REM_W-1:0]   src_rem, shift_rem;
  logic                         shift_done;

  assign out_space = !out_valid_r || out_pop;

  // Merge the waiting bits in front of the new code.
  assign fresh_work  = ({head.code, hcbp_pkg::PEND_W'(0)} >> cnt_r) |
                       {pend_r, hcbp_pkg::AL_W'(0)};
  assign fresh_total = hcbp_pkg::REM_W'(cnt_r) + hcbp_pkg::REM_W'(head.len);

  assign src_work   = busy_r ? work_r : fresh_work;
  assign src_rem    = busy_r ? rem_r  : fresh_total;
  assign shift_work = src_work << hcbp_pkg::BYTE_W;
  assign shift_rem  = src_rem - hcbp_pkg::REM_W'(hcbp_pkg::BYTE_W);
  assign shift_done = shift_rem < hcbp_pkg::REM_W'(hcbp_pkg::BYTE_W);

  always_comb begin
    busy_nxt      = busy_r;
    work_nxt      = work_r;
    rem_nxt       = rem_r;
    pend_nxt      = pend_r;
    cnt_nxt       = cnt_r;
    q_take        = 1'b0;
    out_valid_nxt = out_valid_r && !out_pop;
    out_data_nxt  = out_data_r;

    if (busy_r) begin
      if (out_space) begin
        out_valid_nxt         = 1'b1;
        out_data_nxt.out_byte = src_work[hcbp_pkg::ACC_W-1 -: hcbp_pkg::BYTE_W];
        out_data_nxt.is_miss  = 1'b0;
        out_data_nxt.last     = shift_done;
        work_nxt              = shift_work;
        rem_nxt               = shift_rem;
        if (shift_done) begin
          busy_nxt = 1'b0;
          pend_nxt = shift_work[hcbp_pkg::ACC_W-1 -: hcbp_pkg::PEND_W];
          cnt_nxt  = hcbp_pkg::CNT_W'(shift_rem);
        end
      end
    end else if (q_stat.valid) begin
      unique case (head.kind)
        hcbp_pkg::CMD_MISS: begin
          if (out_space) begin
            q_take                = 1'b1;
            out_valid_nxt         = 1'b1;
            out_data_nxt.out_byte = '0;
            out_data_nxt.is_miss  = 1'b1;
            out_data_nxt.last     = 1'b1;
          end
        end
        hcbp_pkg::CMD_FLUSH: begin
          if (cnt_r == '0) begin
            q_take = 1'b1;
          end else if (out_space) begin
            q_take                = 1'b1;
            out_valid_nxt         = 1'b1;
            out_data_nxt.out_byte = {pend_r, 1'b0};
            out_data_nxt.is_miss  = 1'b0;
            out_data_nxt.last     = 1'b1;
            pend_nxt              = '0;
            cnt_nxt               = '0;
          end
        end
        hcbp_pkg::CMD_ENCODE: begin
          if (fresh_total < hcbp_pkg::REM_W'(hcbp_pkg::BYTE_W)) begin
            q_take   = 1'b1;
            pend_nxt = fresh_work[hcbp_pkg::ACC_W-1 -: hcbp_pkg::PEND_W];
            cnt_nxt  = hcbp_pkg::CNT_W'(fresh_total);
          end else if (out_space) begin
            q_take                = 1'b1;
            out_valid_nxt         = 1'b1;
            out_data_nxt.out_byte = src_work[hcbp_pkg::ACC_W-1 -: hcbp_pkg::BYTE_W];
            out_data_nxt.is_miss  = 1'b0;
            out_data_nxt.last     = shift_done;
            if (shift_done) begin
              pend_nxt = shift_work[hcbp_pkg::ACC_W-1 -: hcbp_pkg::PEND_W];
              cnt_nxt  = hcbp_pkg::CNT_W'(shift_rem);
            end else begin
              busy_nxt = 1'b1;
              work_nxt = shift_work;
              rem_nxt  = shift_rem;
            end
          end
        end
        default: begin
          q_take = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pend_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      pend_r      <= pend_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r     <= work_nxt;
    rem_r      <= rem_nxt;
    out_data_r <= out_data_nxt;
  end

  assign q_pop     = q_take;
  assign out_empty = !out_valid_r;
  assign out_item  = out_data_r;

endmodule
